// ===== rtl/raqp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// raqp_pkg: shared types and constants for the rx queue activation policy
// Queue modes, commands, register indexes and the structs that pass between
// the entry memory, the step logic and the top level.
// ----------------------------------------------------------------------------
package raqp_pkg;

  localparam int NUM_QUEUES_DEFAULT = 64;

  localparam logic [31:0] PROMOTE_TICKS_RESET = 32'd600000;
  localparam logic [31:0] DEMOTE_TICKS_RESET  = 32'd3000000;
  localparam logic        POLICY_ENABLE_RESET = 1'b1;
  localparam logic [1:0]  ARM_MODE_RESET      = 2'd0;

  localparam int CI_BITS = 24;

  typedef enum logic [1:0] {
    CMD_UPDATE   = 2'd0,
    CMD_ARM      = 2'd1,
    CMD_COMPLETE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_ACTIVE    = 2'd0,
    MODE_DISABLING = 2'd1,
    MODE_DISABLED  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CFG_PROMOTE  = 2'd0,
    CFG_DEMOTE   = 2'd1,
    CFG_ENABLE   = 2'd2,
    CFG_ARM_MODE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] retire_gen;
    logic [1:0]  seq;
    mode_t       mode;
  } entry_t;

  typedef struct packed {
    logic [31:0] promote_ticks;
    logic [31:0] demote_ticks;
    logic        policy_enable;
    logic [1:0]  arm_mode_bits;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  active_total;
    logic [6:0]  disabled_total;
    logic [6:0]  armed_total;
    logic [31:0] sw_generation;
  } counts_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [5:0]           queue;
    logic                 q_ok;
    logic                 thread_active;
    logic [63:0]          change_time;
    logic [63:0]          now_time;
    logic [31:0]          hw_generation;
    logic [CI_BITS-1:0]   consumer_index;
    logic [31:0]          cq_number;
  } item_t;

  typedef struct packed {
    logic [63:0] doorbell_word;
    logic        doorbell_valid;
    mode_t       queue_state;
    logic        queue_armed;
    logic [6:0]  active_total;
    logic [6:0]  disabled_total;
    logic [6:0]  armed_total;
    logic [31:0] sw_generation_out;
    logic        steering_stale;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/rx_queue_activation_policy_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rx_queue_activation_policy_core: receive queue activation policy
// Per-queue active/disabling/disabled tracking, arming doorbells and counts.
// ----------------------------------------------------------------------------
// Takes one word per cycle while the output is not stalled and returns one
// result word per input word, taken from the input register into the result
// register. The queue entry memory is read as a word is taken into the input
// register and written as its result is registered, so the entry memory port
// pair sets the rate of one word per cycle; a word for the same queue right
// behind gets the fresh entry through forwarding. No clearing pass is needed
// after reset. Configuration writes are always accepted.
module rx_queue_activation_policy_core #(
  parameter int NUM_QUEUES = raqp_pkg::NUM_QUEUES_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // cfg write channel
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  // input words
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // queue[5:0], thread_active[6], change_time[70:7], now_time[134:71],
  // hw_generation[166:135], consumer_index[190:167], cq_number[230:199]
  input  wire logic [231:0] s_tdata,
  // cmd[1:0]
  input  wire logic [1:0]   s_tuser,
  // result words
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // doorbell_word[63:0], queue_state[65:64], queue_armed[66],
  // active_total[73:67], disabled_total[80:74], armed_total[87:81],
  // sw_generation_out[119:88], steering_stale[120]
  output logic [127:0]      m_tdata,
  // doorbell_valid[0]
  output logic              m_tuser
);
  import raqp_pkg::*;

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int DEPTH = 1 << QW;

  cfg_t             cfg;
  counts_t          counts;
  counts_t          counts_next;
  logic [DEPTH-1:0] armed;
  logic             armed_next;
  logic             s1_valid;
  item_t            item;
  result_t          result;
  result_t          result_next;
  entry_t           entry;
  entry_t           entry_next;
  logic             accept;
  logic             fire;

  assign cfg_ready = 1'b1;
  assign fire      = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !s1_valid || fire;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.promote_ticks <= PROMOTE_TICKS_RESET;
      cfg.demote_ticks  <= DEMOTE_TICKS_RESET;
      cfg.policy_enable <= POLICY_ENABLE_RESET;
      cfg.arm_mode_bits <= ARM_MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PROMOTE:  cfg.promote_ticks <= cfg_data;
        CFG_DEMOTE:   cfg.demote_ticks  <= cfg_data;
        CFG_ENABLE:   cfg.policy_enable <= cfg_data[0];
        CFG_ARM_MODE: cfg.arm_mode_bits <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
      counts   <= '{active_total: 7'(NUM_QUEUES), disabled_total: 7'd0,
                    armed_total: 7'd0, sw_generation: 32'd0};
      armed    <= '0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (fire) begin
        counts <= counts_next;
        if (item.q_ok) begin
          armed[item.queue[QW-1:0]] <= armed_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.cmd            <= cmd_t'(s_tuser);
      item.queue          <= s_tdata[5:0];
      item.q_ok           <= 7'(s_tdata[5:0]) < 7'(NUM_QUEUES);
      item.thread_active  <= s_tdata[6];
      item.change_time    <= s_tdata[70:7];
      item.now_time       <= s_tdata[134:71];
      item.hw_generation  <= s_tdata[166:135];
      item.consumer_index <= s_tdata[190:167];
      item.cq_number      <= s_tdata[230:199];
    end
    if (fire) begin
      result <= result_next;
    end
  end

  raqp_entry_ram #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_entry_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (s_tdata[QW-1:0]),
    .rd_data (entry),
    .wr_en   (fire && item.q_ok),
    .wr_addr (item.queue[QW-1:0]),
    .wr_data (entry_next)
  );

  raqp_step u_step (
    .item        (item),
    .entry       (entry),
    .cfg         (cfg),
    .counts      (counts),
    .armed_cur   (armed[item.queue[QW-1:0]]),
    .entry_next  (entry_next),
    .counts_next (counts_next),
    .armed_next  (armed_next),
    .result_next (result_next)
  );

  assign m_tdata = {7'd0, result.steering_stale, result.sw_generation_out,
                    result.armed_total, result.disabled_total, result.active_total,
                    result.queue_armed, result.queue_state, result.doorbell_word};
  assign m_tuser = result.doorbell_valid;

  // demotion never takes the last active queue
  a_active_floor: assert property (@(posedge clk) disable iff (rst)
    counts.active_total != 7'd0)
    else $error("active queue count reached zero");

  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    (8'(counts.active_total) + 8'(counts.disabled_total)) <= 8'(NUM_QUEUES))
    else $error("active plus disabled queues exceed the queue count");

  a_armed_pop: assert property (@(posedge clk) disable iff (rst)
    counts.armed_total == 7'($countones(armed)))
    else $error("armed count out of step with armed marks");

  a_db_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[63:0] == 64'd0))
    else $error("doorbell word set without a doorbell");

endmodule
`default_nettype wire

// ===== rtl/raqp_entry_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// raqp_entry_ram: per-queue entry store
// One write and one registered read port, a valid bit per entry so that an
// unwritten entry reads as the reset entry, and forwarding of a write that
// lands on the address read in the same cycle.
// ----------------------------------------------------------------------------
module raqp_entry_ram #(
  parameter int  NUM_QUEUES = raqp_pkg::NUM_QUEUES_DEFAULT,
  localparam int QW         = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    rd_en,
  input  wire logic [QW-1:0]           rd_addr,
  output raqp_pkg::entry_t             rd_data,
  input  wire logic                    wr_en,
  input  wire logic [QW-1:0]           wr_addr,
  input  raqp_pkg::entry_t             wr_data
);
  import raqp_pkg::*;

  localparam int DEPTH = 1 << QW;

  entry_t             mem [DEPTH];
  logic [DEPTH-1:0]   vld;
  entry_t             rd_raw;
  logic               rd_vld;
  logic               byp_hit;
  entry_t             byp_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // read-during-write to the same entry takes the new data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld   <= vld[rd_addr];
      byp_hit  <= wr_en && (wr_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp_hit ? byp_data : (rd_vld ? rd_raw : entry_t'('0));

endmodule
`default_nettype wire

// ===== rtl/raqp_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// raqp_step: activation policy and doorbell logic for one word
// Takes the registered item, its queue entry and the counters, and gives the
// updated entry, counters, armed mark and the result word.
// ----------------------------------------------------------------------------
module raqp_step (
  input  raqp_pkg::item_t   item,
  input  raqp_pkg::entry_t  entry,
  input  raqp_pkg::cfg_t    cfg,
  input  raqp_pkg::counts_t counts,
  input  wire logic         armed_cur,
  output raqp_pkg::entry_t  entry_next,
  output raqp_pkg::counts_t counts_next,
  output logic              armed_next,
  output raqp_pkg::result_t result_next
);
  import raqp_pkg::*;

  logic [63:0] elapsed;
  logic        prom_ok;
  logic        dem_ok;

  assign elapsed = item.now_time - item.change_time;
  // strictly greater than a 32-bit delay
  assign prom_ok = (elapsed[63:32] != 32'd0) || (elapsed[31:0] > cfg.promote_ticks);
  assign dem_ok  = (elapsed[63:32] != 32'd0) || (elapsed[31:0] > cfg.demote_ticks);

  always_comb begin
    mode_t       mode;
    logic [31:0] gen;
    logic [1:0]  seq;
    logic [63:0] db;
    logic        dbv;
    counts_t     cn;
    logic        arm_n;

    mode  = entry.mode;
    gen   = entry.retire_gen;
    seq   = entry.seq;
    db    = 64'd0;
    dbv   = 1'b0;
    cn    = counts;
    arm_n = armed_cur;

    if (item.q_ok) begin
      case (item.cmd)
        CMD_UPDATE: begin
          if (cfg.policy_enable) begin
            if (mode == MODE_DISABLING && gen <= item.hw_generation) begin
              mode              = MODE_DISABLED;
              cn.disabled_total = cn.disabled_total + 7'd1;
            end
            if (item.thread_active) begin
              if (mode != MODE_ACTIVE && prom_ok) begin
                if (mode == MODE_DISABLED) begin
                  cn.disabled_total = cn.disabled_total - 7'd1;
                end
                mode             = MODE_ACTIVE;
                cn.active_total  = cn.active_total + 7'd1;
                cn.sw_generation = cn.sw_generation + 32'd1;
              end
            end else if (counts.active_total > 7'd1 && mode == MODE_ACTIVE && dem_ok) begin
              cn.sw_generation = cn.sw_generation + 32'd1;
              gen              = cn.sw_generation;
              mode             = MODE_DISABLING;
              cn.active_total  = cn.active_total - 7'd1;
            end
          end
        end
        CMD_ARM: begin
          db  = {2'b00, seq, 2'b00, cfg.arm_mode_bits, item.consumer_index, item.cq_number};
          dbv = 1'b1;
          seq = seq + 2'd1;
          if (!armed_cur) begin
            arm_n          = 1'b1;
            cn.armed_total = cn.armed_total + 7'd1;
          end
        end
        CMD_COMPLETE: begin
          if (armed_cur) begin
            arm_n          = 1'b0;
            cn.armed_total = cn.armed_total - 7'd1;
          end
        end
        default: begin
        end
      endcase
    end

    entry_next  = '{retire_gen: gen, seq: seq, mode: mode};
    counts_next = cn;
    armed_next  = arm_n;

    result_next.doorbell_word     = db;
    result_next.doorbell_valid    = dbv;
    result_next.queue_state       = item.q_ok ? mode : MODE_ACTIVE;
    result_next.queue_armed       = item.q_ok && arm_n;
    result_next.active_total      = cn.active_total;
    result_next.disabled_total    = cn.disabled_total;
    result_next.armed_total       = cn.armed_total;
    result_next.sw_generation_out = cn.sw_generation;
    result_next.steering_stale    = item.hw_generation < cn.sw_generation;
  end

endmodule
`default_nettype wire
